// File: src/prom_pkg.sv
// shared types and constants for the periodic release / overrun monitor
// no dependencies; used by prom_lane, prom_merge and the top level
package prom_pkg;

  localparam int unsigned MAX_TASKS = 4;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned STREAK_W  = 8;
  localparam int unsigned OVR_W     = 16;
  localparam int unsigned RESP_W    = 24;
  localparam int unsigned TIDX_W    = 2;
  localparam int unsigned CFG_IDX_W = 4;

  // register index map
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_BASE  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REG_END     = 4'd8;

  // what one lane reports for one tick
  typedef struct packed {
    logic              job_finished;
    logic [RESP_W-1:0] response_time;
    logic [RESP_W-1:0] max_response;
    logic              resume_request;
    logic              overrun_event;
    logic [OVR_W-1:0]  overrun_total;
  } lane_res_t;

endpackage

// File: src/prom_lane.sv
// one task lane: release countdown, job tracking and response-time math
// depends on prom_pkg
module prom_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      idle_i,
  input  logic [prom_pkg::CNT_W-1:0] period_i,
  input  logic                      phase_load_i,
  input  logic [prom_pkg::CNT_W-1:0] phase_i,
  output prom_pkg::lane_res_t       res_o
);

  localparam int unsigned MUL_W = prom_pkg::CNT_W + prom_pkg::STREAK_W + 1;

  logic [prom_pkg::CNT_W-1:0]    cnt_q, cnt_d, cnt_dec;
  logic                          pend_q, pend_d;
  logic [prom_pkg::STREAK_W-1:0] streak_q, streak_d;
  logic [prom_pkg::OVR_W-1:0]    ovr_q, ovr_d;
  logic [prom_pkg::RESP_W-1:0]   worst_q, worst_d;
  logic                          fin, rel;
  logic [MUL_W-1:0]              scaled, diff;
  logic [prom_pkg::RESP_W-1:0]   resp;

  assign cnt_dec = cnt_q - prom_pkg::CNT_W'(1);
  assign fin     = pend_q & idle_i;
  assign rel     = (cnt_dec == '0);

  // period * (1 + streak), then minus the remaining countdown, clamped both ways
  assign scaled = MUL_W'(period_i) * MUL_W'({1'b0, streak_q} + 9'd1);
  assign diff   = scaled - MUL_W'(cnt_dec);

  always_comb begin
    if (MUL_W'(cnt_dec) >= scaled) begin
      resp = '0;
    end else if (diff[MUL_W-1:prom_pkg::RESP_W] != '0) begin
      resp = '1;
    end else begin
      resp = diff[prom_pkg::RESP_W-1:0];
    end
  end

  always_comb begin
    worst_d  = worst_q;
    streak_d = streak_q;
    ovr_d    = ovr_q;
    pend_d   = pend_q;
    cnt_d    = cnt_dec;
    if (fin) begin
      pend_d   = 1'b0;
      streak_d = '0;
      if (resp > worst_q) begin
        worst_d = resp;
      end
    end
    if (rel) begin
      pend_d = 1'b1;
      cnt_d  = period_i;
      if (!idle_i) begin
        if (ovr_q != '1) begin
          ovr_d = ovr_q + prom_pkg::OVR_W'(1);
        end
        if (streak_d != '1) begin
          streak_d = streak_d + prom_pkg::STREAK_W'(1);
        end
      end
    end
  end

  assign res_o.job_finished   = fin;
  assign res_o.response_time  = fin ? resp : '0;
  assign res_o.max_response   = worst_d;
  assign res_o.resume_request = rel & idle_i;
  assign res_o.overrun_event  = rel & ~idle_i;
  assign res_o.overrun_total  = ovr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= prom_pkg::CNT_W'(1);
      pend_q   <= 1'b0;
      streak_q <= '0;
      ovr_q    <= '0;
      worst_q  <= '0;
    end else if (phase_load_i) begin
      cnt_q <= phase_i;
    end else if (step_i) begin
      cnt_q    <= cnt_d;
      pend_q   <= pend_d;
      streak_q <= streak_d;
      ovr_q    <= ovr_d;
      worst_q  <= worst_d;
    end
  end

endmodule

// File: src/prom_merge.sv
// merge stage: captures all lane results of a tick and sends them out in task order
// depends on prom_pkg
module prom_merge #(
  parameter int unsigned TASK_COUNT = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  prom_pkg::lane_res_t          res_i [TASK_COUNT],
  output logic                         busy_o,
  output logic                         last_go_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [prom_pkg::TIDX_W-1:0]  task_index_o,
  output prom_pkg::lane_res_t          res_o,
  output logic                         last_of_tick_o
);

  localparam int unsigned PTR_W = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(TASK_COUNT - 1);

  prom_pkg::lane_res_t buf_q [TASK_COUNT];
  logic [PTR_W-1:0]    ptr_q;
  logic                busy_q;
  logic                last, go;

  assign last      = (ptr_q == LAST_PTR);
  assign go        = busy_q & ~out_stall_i;
  assign last_go_o = go & last;
  assign busy_o    = busy_q;

  assign out_valid_o    = busy_q;
  assign task_index_o   = prom_pkg::TIDX_W'(ptr_q);
  assign res_o          = buf_q[ptr_q];
  assign last_of_tick_o = last;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      buf_q <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ptr_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      ptr_q  <= '0;
    end else if (go) begin
      if (last) begin
        busy_q <= 1'b0;
        ptr_q  <= '0;
      end else begin
        ptr_q <= ptr_q + PTR_W'(1);
      end
    end
  end

  a_load_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> (!busy_q || (last && !out_stall_i)))
    else $error("tick captured while results still pending");

  a_load_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (out_valid_o && ptr_q == '0))
    else $error("capture did not restart the sequence at task zero");

  a_sequence_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && !last) |=> (out_valid_o && ptr_q == $past(ptr_q) + PTR_W'(1)))
    else $error("result sequence broken before last task");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && last && !load_i) |=> !out_valid_o)
    else $error("output still valid after last task of tick");

endmodule

// File: src/periodic_release_overrun_monitor.sv
// top level of the periodic release / overrun monitor
// depends on prom_pkg, prom_lane and prom_merge
//
// usage:
//   input channel (in_valid_i / in_stall_o): one transfer per timer tick,
//   carrying idle_mask_i, bit i set when task i is suspended
//   output channel (out_valid_o / out_stall_i): TASK_COUNT transfers per
//   tick, task 0 first, last_of_tick_o set on the final one
//   config channel (cfg_valid_i / cfg_ready_o): index 0..3 writes a period,
//   4..7 a phase (which also reloads that task's countdown); other indexes
//   are dropped; always ready, write only while no tick is in flight
// latency: the first result of a tick is valid the cycle after its transfer
// throughput: the merge stage emits one lane result per cycle while the
//   receiver does not stall; a new tick is taken in the same cycle the last
//   result of the previous one transfers
// reset: countdowns at 1, no job pending, streaks, counts and maxima zero,
//   periods 1; no results pending
// stall: results hold steady, and the input stays stalled until the last
//   result of the current tick has transferred
module periodic_release_overrun_monitor #(
  parameter int unsigned TASK_COUNT = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tick input
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [prom_pkg::MAX_TASKS-1:0]   idle_mask_i,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [prom_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [prom_pkg::CNT_W-1:0]       cfg_data_i,
  // per-task results
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [prom_pkg::TIDX_W-1:0]      task_index_o,
  output logic                             job_finished_o,
  output logic [prom_pkg::RESP_W-1:0]      response_time_o,
  output logic [prom_pkg::RESP_W-1:0]      max_response_o,
  output logic                             resume_request_o,
  output logic                             overrun_event_o,
  output logic [prom_pkg::OVR_W-1:0]       overrun_total_o,
  output logic                             last_of_tick_o
);

  logic [prom_pkg::CNT_W-1:0] period_q [TASK_COUNT];
  prom_pkg::lane_res_t        lane_res [TASK_COUNT];
  prom_pkg::lane_res_t        out_res;
  logic                       in_xfer, cfg_xfer;
  logic                       wr_period, wr_phase;
  logic [1:0]                 wr_lane;
  logic                       busy, last_go;

  // one tick at a time; free again as the last result leaves
  assign in_stall_o = busy & ~last_go;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  // config register decode
  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i & cfg_ready_o;
  assign wr_period   = cfg_xfer && (cfg_index_i < prom_pkg::CFG_PHASE_BASE);
  assign wr_phase    = cfg_xfer && (cfg_index_i >= prom_pkg::CFG_PHASE_BASE)
                                && (cfg_index_i <  prom_pkg::CFG_REG_END);
  assign wr_lane     = cfg_index_i[1:0];

  for (genvar i = 0; i < TASK_COUNT; i++) begin : g_lane
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        period_q[i] <= prom_pkg::CNT_W'(1);
      end else if (wr_period && wr_lane == 2'(i)) begin
        period_q[i] <= cfg_data_i;
      end
    end

    prom_lane u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .step_i       (in_xfer),
      .idle_i       (idle_mask_i[i]),
      .period_i     (period_q[i]),
      .phase_load_i (wr_phase && wr_lane == 2'(i)),
      .phase_i      (cfg_data_i),
      .res_o        (lane_res[i])
    );
  end

  // serialize the lane results in task order
  prom_merge #(
    .TASK_COUNT (TASK_COUNT)
  ) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (in_xfer),
    .res_i          (lane_res),
    .busy_o         (busy),
    .last_go_o      (last_go),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .task_index_o   (task_index_o),
    .res_o          (out_res),
    .last_of_tick_o (last_of_tick_o)
  );

  assign job_finished_o   = out_res.job_finished;
  assign response_time_o  = out_res.response_time;
  assign max_response_o   = out_res.max_response;
  assign resume_request_o = out_res.resume_request;
  assign overrun_event_o  = out_res.overrun_event;
  assign overrun_total_o  = out_res.overrun_total;

endmodule

// File: tb/prom_result_checker.sv
`timescale 1ns / 1ps
// result checker for periodic_release_overrun_monitor: predicts the per-task
// reports of every tick and compares them with the result channel; uses prom_pkg
module prom_result_checker #(
  parameter int unsigned TASK_COUNT = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           tick_valid_i,
  input  logic                           tick_stall_i,
  input  logic [prom_pkg::MAX_TASKS-1:0] idle_mask_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [prom_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [prom_pkg::CNT_W-1:0]     cfg_data_i,
  input  logic                           res_valid_i,
  input  logic                           res_stall_i,
  input  logic [prom_pkg::TIDX_W-1:0]    task_index_i,
  input  logic                           job_finished_i,
  input  logic [prom_pkg::RESP_W-1:0]    response_time_i,
  input  logic [prom_pkg::RESP_W-1:0]    max_response_i,
  input  logic                           resume_request_i,
  input  logic                           overrun_event_i,
  input  logic [prom_pkg::OVR_W-1:0]     overrun_total_i,
  input  logic                           last_of_tick_i,
  output int                             mismatch_count_o,
  output int                             results_owed_o
);

  localparam int unsigned MAX_PRINTED = 40;

  typedef struct packed {
    logic [prom_pkg::TIDX_W-1:0] task_index;
    prom_pkg::lane_res_t         lane;
    logic                        last_of_tick;
  } task_report_t;

  logic [prom_pkg::CNT_W-1:0]    period_q    [prom_pkg::MAX_TASKS];
  logic [prom_pkg::CNT_W-1:0]    countdown_q [prom_pkg::MAX_TASKS];
  logic                          pending_q   [prom_pkg::MAX_TASKS];
  logic [prom_pkg::STREAK_W-1:0] streak_q    [prom_pkg::MAX_TASKS];
  logic [prom_pkg::OVR_W-1:0]    overruns_q  [prom_pkg::MAX_TASKS];
  logic [prom_pkg::RESP_W-1:0]   worst_q     [prom_pkg::MAX_TASKS];

  task_report_t expected_reports[$];
  int mismatches = 0;
  int printed = 0;
  int owed = 0;

  assign mismatch_count_o = mismatches;
  assign results_owed_o   = owed;

  task automatic report_mismatch(input string what, input int tsk,
                                 input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    if (printed < MAX_PRINTED) begin
      printed++;
      $display("%0t: task %0d %s: got %0d expected %0d", $realtime, tsk, what, got, want);
    end
  endtask

  // period * (1 + streak) - countdown, clamped to the 24-bit range
  function automatic logic [prom_pkg::RESP_W-1:0] response_for(input int t);
    logic [31:0] scaled;
    logic [31:0] per;
    logic [31:0] cnt;
    logic [31:0] runs;
    per = period_q[t];
    cnt = countdown_q[t];
    runs = streak_q[t];
    scaled = per * (runs + 32'd1);
    if (cnt >= scaled) return '0;
    scaled = scaled - cnt;
    if (scaled > 32'h00FF_FFFF) return '1;
    return scaled[prom_pkg::RESP_W-1:0];
  endfunction

  task automatic apply_write(input logic [prom_pkg::CFG_IDX_W-1:0] idx,
                             input logic [prom_pkg::CNT_W-1:0] value);
    if (idx < prom_pkg::CFG_PHASE_BASE) begin
      period_q[prom_pkg::TIDX_W'(idx - prom_pkg::CFG_PERIOD_BASE)] = value;
    end else if (idx < prom_pkg::CFG_REG_END) begin
      countdown_q[prom_pkg::TIDX_W'(idx - prom_pkg::CFG_PHASE_BASE)] = value;
    end
  endtask

  task automatic advance_tick(input logic [prom_pkg::MAX_TASKS-1:0] mask);
    task_report_t rep;
    logic idle;
    for (int t = 0; t < TASK_COUNT; t++) begin
      idle = mask[t];
      rep = '0;
      rep.task_index = prom_pkg::TIDX_W'(t);
      countdown_q[t] = countdown_q[t] - 1'b1;
      if (pending_q[t] && idle) begin
        pending_q[t] = 1'b0;
        rep.lane.job_finished = 1'b1;
        rep.lane.response_time = response_for(t);
        if (rep.lane.response_time > worst_q[t]) worst_q[t] = rep.lane.response_time;
        streak_q[t] = '0;
      end
      if (countdown_q[t] == '0) begin
        pending_q[t] = 1'b1;
        countdown_q[t] = period_q[t];
        if (idle) begin
          rep.lane.resume_request = 1'b1;
        end else begin
          rep.lane.overrun_event = 1'b1;
          if (overruns_q[t] != '1) overruns_q[t] = overruns_q[t] + 1'b1;
          if (streak_q[t] != '1) streak_q[t] = streak_q[t] + 1'b1;
        end
      end
      rep.lane.max_response = worst_q[t];
      rep.lane.overrun_total = overruns_q[t];
      rep.last_of_tick = (t == TASK_COUNT - 1);
      expected_reports.push_back(rep);
    end
  endtask

  task automatic check_report();
    task_report_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch("result with nothing expected", task_index_i, task_index_i, 0);
      return;
    end
    want = expected_reports.pop_front();
    if (task_index_i !== want.task_index)
      report_mismatch("task_index", want.task_index, task_index_i, want.task_index);
    if (job_finished_i !== want.lane.job_finished)
      report_mismatch("job_finished", want.task_index, job_finished_i,
                      want.lane.job_finished);
    if (response_time_i !== want.lane.response_time)
      report_mismatch("response_time", want.task_index, response_time_i,
                      want.lane.response_time);
    if (max_response_i !== want.lane.max_response)
      report_mismatch("max_response", want.task_index, max_response_i,
                      want.lane.max_response);
    if (resume_request_i !== want.lane.resume_request)
      report_mismatch("resume_request", want.task_index, resume_request_i,
                      want.lane.resume_request);
    if (overrun_event_i !== want.lane.overrun_event)
      report_mismatch("overrun_event", want.task_index, overrun_event_i,
                      want.lane.overrun_event);
    if (overrun_total_i !== want.lane.overrun_total)
      report_mismatch("overrun_total", want.task_index, overrun_total_i,
                      want.lane.overrun_total);
    if (last_of_tick_i !== want.last_of_tick)
      report_mismatch("last_of_tick", want.task_index, last_of_tick_i, want.last_of_tick);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < prom_pkg::MAX_TASKS; t++) begin
        period_q[t] = 16'd1;
        countdown_q[t] = 16'd1;
        pending_q[t] = 1'b0;
        streak_q[t] = '0;
        overruns_q[t] = '0;
        worst_q[t] = '0;
      end
      expected_reports.delete();
      owed <= 0;
    end else begin
      // results of an earlier tick leave before a new tick is predicted
      if (res_valid_i && !res_stall_i) check_report();
      if (cfg_valid_i && cfg_ready_i) apply_write(cfg_index_i, cfg_data_i);
      if (tick_valid_i && !tick_stall_i) advance_tick(idle_mask_i);
      owed <= expected_reports.size();
    end
  end

endmodule

// File: tb/periodic_release_overrun_monitor_tb.sv
`timescale 1ns / 1ps
// testbench top for periodic_release_overrun_monitor: drives ticks, register
// writes and result stalls; depends on prom_pkg, the block and prom_result_checker
module periodic_release_overrun_monitor_tb;

  localparam int unsigned TASK_COUNT = 4;
  localparam int unsigned BURST_TICKS = 6;
  localparam int unsigned SATURATE_TICKS = 258;
  localparam logic [prom_pkg::CFG_IDX_W-1:0] CFG_IDX_LAST = '1;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [prom_pkg::MAX_TASKS-1:0] idle_mask_i = '0;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [prom_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [prom_pkg::CNT_W-1:0]     cfg_data_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [prom_pkg::TIDX_W-1:0]    task_index_o;
  logic                           job_finished_o;
  logic [prom_pkg::RESP_W-1:0]    response_time_o;
  logic [prom_pkg::RESP_W-1:0]    max_response_o;
  logic                           resume_request_o;
  logic                           overrun_event_o;
  logic [prom_pkg::OVR_W-1:0]     overrun_total_o;
  logic                           last_of_tick_o;

  int mismatch_count;
  int results_owed;

  // percent of cycles the tick source holds back / the result sink stalls
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  periodic_release_overrun_monitor #(
    .TASK_COUNT(TASK_COUNT)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .idle_mask_i     (idle_mask_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .task_index_o    (task_index_o),
    .job_finished_o  (job_finished_o),
    .response_time_o (response_time_o),
    .max_response_o  (max_response_o),
    .resume_request_o(resume_request_o),
    .overrun_event_o (overrun_event_o),
    .overrun_total_o (overrun_total_o),
    .last_of_tick_o  (last_of_tick_o)
  );

  prom_result_checker #(
    .TASK_COUNT(TASK_COUNT)
  ) checker_u (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tick_valid_i    (in_valid_i),
    .tick_stall_i    (in_stall_o),
    .idle_mask_i     (idle_mask_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .res_valid_i     (out_valid_o),
    .res_stall_i     (out_stall_i),
    .task_index_i    (task_index_o),
    .job_finished_i  (job_finished_o),
    .response_time_i (response_time_o),
    .max_response_i  (max_response_o),
    .resume_request_i(resume_request_o),
    .overrun_event_i (overrun_event_o),
    .overrun_total_i (overrun_total_o),
    .last_of_tick_i  (last_of_tick_o),
    .mismatch_count_o(mismatch_count),
    .results_owed_o  (results_owed)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result sink back-pressure, changed on the falling edge only
  always @(negedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // hard limit on the run, far above the slowest legal run
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // all tasks below enter and leave on a falling edge, with no pending
  // assignment to the signal they touch first

  // one register write; valid is dropped once the write is taken, so that back-to-back
  // writes never assign cfg_valid_i twice in one step
  task automatic write_reg(input logic [prom_pkg::CFG_IDX_W-1:0] idx,
                           input logic [prom_pkg::CNT_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // one tick transfer, preceded by a random gap; valid stays high on return
  // so that the next tick can follow with no bubble
  task automatic send_tick(input logic [prom_pkg::MAX_TASKS-1:0] mask);
    while ((gap_pct != 0) && ($urandom_range(99) < gap_pct)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    idle_mask_i <= mask;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // stop sending and let every predicted result come out, so that the block
  // is idle before the registers change
  task automatic drain();
    in_valid_i <= 1'b0;
    while (results_owed != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // mostly short periods so releases, overruns and streaks happen often,
  // now and then zero, the maximum or anything
  function automatic logic [prom_pkg::CNT_W-1:0] pick_reg_value();
    int unsigned sel;
    sel = $urandom_range(15);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel == 2) return prom_pkg::CNT_W'($urandom_range(65535));
    return prom_pkg::CNT_W'($urandom_range(6, 1));
  endfunction

  // each task is idle with the given chance
  function automatic logic [prom_pkg::MAX_TASKS-1:0] random_mask(input int unsigned pct);
    logic [prom_pkg::MAX_TASKS-1:0] m;
    for (int b = 0; b < prom_pkg::MAX_TASKS; b++) m[b] = ($urandom_range(99) < pct);
    return m;
  endfunction

  initial begin
    int unsigned idle_pct;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part, no idling on either side
    // reset values: every task releases on the first tick while running
    // (overrun), then finishes on the next with a streak of one
    send_tick(4'h0);
    send_tick(4'hF);
    drain();

    // zero and maximum periods and phases; zero countdown wraps to the top,
    // a zero period reloads zero and wraps on the following tick
    write_reg(prom_pkg::CFG_PERIOD_BASE + 4'd0, 16'd2);
    write_reg(prom_pkg::CFG_PERIOD_BASE + 4'd1, 16'd0);
    write_reg(prom_pkg::CFG_PERIOD_BASE + 4'd2, 16'hFFFF);
    write_reg(prom_pkg::CFG_PERIOD_BASE + 4'd3, 16'd3);
    write_reg(prom_pkg::CFG_PHASE_BASE + 4'd0, 16'd1);
    write_reg(prom_pkg::CFG_PHASE_BASE + 4'd1, 16'd0);
    write_reg(prom_pkg::CFG_PHASE_BASE + 4'd2, 16'hFFFF);
    write_reg(prom_pkg::CFG_PHASE_BASE + 4'd3, 16'd2);
    // indexes past the register map must be dropped
    write_reg(prom_pkg::CFG_REG_END, 16'hFFFF);
    write_reg(CFG_IDX_LAST, 16'h0000);
    send_tick(4'h0);
    send_tick(4'hF);
    send_tick(4'h1);
    send_tick(4'h2);
    send_tick(4'h4);
    send_tick(4'h8);
    send_tick(4'h5);
    send_tick(4'hA);
    send_tick(4'h0);
    send_tick(4'h0);
    send_tick(4'hF);
    send_tick(4'hE);
    send_tick(4'h7);
    send_tick(4'h0);
    drain();

    // a phase write reloads the countdown above period * (1 + streak) while a
    // job is pending, so the response clamps at zero
    write_reg(prom_pkg::CFG_PHASE_BASE + 4'd0, 16'hFFFF);
    write_reg(prom_pkg::CFG_PERIOD_BASE + 4'd3, 16'd0);
    send_tick(4'hF);
    send_tick(4'h0);
    send_tick(4'h0);
    send_tick(4'hF);
    drain();

    // random part: four idling modes, two register settings in each
    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 65;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 65;
        end
        default: begin
          gap_pct = 11;
          stall_pct = 11;
        end
      endcase
      for (int half = 0; half < 2; half++) begin
        for (int t = 0; t < prom_pkg::MAX_TASKS; t++) begin
          write_reg(prom_pkg::CFG_IDX_W'(prom_pkg::CFG_PERIOD_BASE + t), pick_reg_value());
          write_reg(prom_pkg::CFG_IDX_W'(prom_pkg::CFG_PHASE_BASE + t), pick_reg_value());
        end
        if ($urandom_range(1) == 1)
          write_reg(prom_pkg::CFG_IDX_W'(prom_pkg::CFG_REG_END + $urandom_range(7)),
                    prom_pkg::CNT_W'($urandom_range(65535)));
        // busy settings build overrun streaks, idle ones finish jobs
        idle_pct = $urandom_range(85, 15);
        repeat (BURST_TICKS) send_tick(random_mask(idle_pct));
        drain();
      end
    end

    // saturation: every task overruns on every tick, long enough for the streak to stop
    // at its top, then all finish with the largest scaled period
    gap_pct = 0;
    stall_pct = 0;
    for (int t = 0; t < prom_pkg::MAX_TASKS; t++) begin
      write_reg(prom_pkg::CFG_IDX_W'(prom_pkg::CFG_PERIOD_BASE + t), 16'd1);
      write_reg(prom_pkg::CFG_IDX_W'(prom_pkg::CFG_PHASE_BASE + t), 16'd1);
    end
    repeat (SATURATE_TICKS) send_tick(4'h0);
    send_tick(4'hF);
    send_tick(4'h0);
    send_tick(4'hF);
    drain();

    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
src/prom_pkg.sv
src/prom_lane.sv
src/prom_merge.sv
src/periodic_release_overrun_monitor.sv
tb/prom_result_checker.sv
tb/periodic_release_overrun_monitor_tb.sv
